// ===== hw/rtl/smm_pkg.sv =====
// package for the strassen one-level matrix multiplier
// holds the sequencer state type and register address codes; no dependencies
package smm_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD,
    ST_MAC,
    ST_COMB,
    ST_OUT
  } state_t;

  localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

endpackage

// ===== hw/rtl/strassen_one_level_matrix_multiply_unit.sv =====
// top level of the strassen one-level matrix multiplier
// uses smm_pkg for the sequencer state type and register codes
//
//   config: apb-style port, matrix_size at byte address 0; a write drops any partly
//   loaded matrices. size 0 acts as 1, above MAX_ORDER as MAX_ORDER.
//   input: one (a, b) element pair per item, row-major, taken when in_start is high
//   and in_busy is low. items that do not complete the matrices leave in_busy low.
//   compute: per quadrant position (p,q) and each r, a read phase fetches the eight
//   quadrant elements (four reads, then the last read lands), then the seven strassen
//   products run through one shared multiply-accumulate. a combine per (p,q) then
//   writes one product block a cycle.
//   output: n*n results row-major, one per cycle, each for one cycle under
//   out_valid, the first registered after the combine; out_last marks the final
//   element, and in_busy drops in that cycle. the receiver cannot stall.
//   reset: synchronous active-low rst_n clears the load count and sequencer and
//   sets matrix_size to MAX_ORDER. the element stores are not cleared.
module strassen_one_level_matrix_multiply_unit #(
  parameter int MAX_ORDER    = 8,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_start,
  output logic                            in_busy,
  input  logic signed [ELEMENT_BITS-1:0]  in_a_value,
  input  logic signed [ELEMENT_BITS-1:0]  in_b_value,
  output logic                            out_valid,
  output logic signed [2*ELEMENT_BITS+2:0] out_c_value,
  output logic [2:0]                      out_row,
  output logic [2:0]                      out_col,
  output logic                            out_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [1:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
  localparam int AW     = $clog2(DEPTH);
  localparam int HALF   = (MAX_ORDER + 1) / 2;
  localparam int PAD    = 2 * HALF;
  localparam int HW     = $clog2(HALF + 1);
  localparam int CW     = $clog2(PAD);
  localparam int CDEPTH = 1 << (2 * CW);
  localparam int OW     = 2 * ELEMENT_BITS + 3;
  localparam int EW     = ELEMENT_BITS + 1;
  localparam int CNTW   = $clog2(DEPTH + 1);

  // register port
  logic [3:0] size_r;
  logic       wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[1] == smm_pkg::REG_MATRIX_SIZE)
                  && (paddr[0] == 1'b0);
  assign prdata = (paddr[1] == smm_pkg::REG_MATRIX_SIZE) ? {28'd0, size_r} : 32'd0;

  // order in use and half size
  logic [3:0]    n_use;
  logic [HW-1:0] h_use;
  always_comb begin
    n_use = size_r;
    if (size_r == 4'd0) n_use = 4'd1;
    if (32'(size_r) > MAX_ORDER) n_use = 4'(MAX_ORDER);
    h_use = HW'((32'(n_use) + 1) / 2);
  end

  logic [CNTW-1:0] total;
  assign total = CNTW'(32'(n_use) * 32'(n_use));

  smm_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [HW-1:0]   p_r, p_nxt, q_r, q_nxt, r_r, r_nxt;
  logic [2:0]      ph_r, ph_nxt;       // read phase, product index or block index
  logic [CW-1:0]   oi_r, oi_nxt, oj_r, oj_nxt;

  logic accept;
  assign in_busy = (state_r != smm_pkg::ST_LOAD);
  assign accept  = in_start && !in_busy;

  // element stores, one read port each
  logic [ELEMENT_BITS-1:0] a_mem [DEPTH];
  logic [ELEMENT_BITS-1:0] b_mem [DEPTH];
  logic [ELEMENT_BITS-1:0] a_rd_r, b_rd_r;
  logic                    a_z_r, b_z_r;
  logic [AW-1:0]           a_addr, b_addr;
  logic                    a_zero, b_zero;
  logic [CNTW-1:0]         wr_idx;

  assign wr_idx = (cnt_r >= total) ? '0 : cnt_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mem[wr_idx[AW-1:0]] <= in_a_value;
      b_mem[wr_idx[AW-1:0]] <= in_b_value;
    end
    a_rd_r <= a_mem[a_addr];
    b_rd_r <= b_mem[b_addr];
    a_z_r  <= a_zero;
    b_z_r  <= b_zero;
  end

  // read phase k reads quadrant k: a at (p, r), b at (r, q)
  always_comb begin
    logic [4:0] ai, aj, bi, bj;
    ai = 5'(p_r) + (ph_r[1] ? 5'(h_use) : 5'd0);
    aj = 5'(r_r) + (ph_r[0] ? 5'(h_use) : 5'd0);
    bi = 5'(r_r) + (ph_r[1] ? 5'(h_use) : 5'd0);
    bj = 5'(q_r) + (ph_r[0] ? 5'(h_use) : 5'd0);
    a_zero = (ai >= 5'(n_use)) || (aj >= 5'(n_use));
    b_zero = (bi >= 5'(n_use)) || (bj >= 5'(n_use));
    a_addr = AW'(32'(ai) * 32'(n_use) + 32'(aj));
    b_addr = AW'(32'(bi) * 32'(n_use) + 32'(bj));
  end

  // quadrant element registers
  logic signed [ELEMENT_BITS-1:0] qa_r [4];
  logic signed [ELEMENT_BITS-1:0] qb_r [4];
  logic                           rd_valid_r;
  logic [1:0]                     rd_k_r;

  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      qa_r[rd_k_r] <= a_z_r ? '0 : a_rd_r;
      qb_r[rd_k_r] <= b_z_r ? '0 : b_rd_r;
    end
  end

  // operand select for the shared multiplier
  logic signed [EW-1:0] opx, opy;
  always_comb begin
    logic signed [EW-1:0] a0, a1, a2, a3, b0, b1, b2, b3;
    a0 = EW'(qa_r[0]); a1 = EW'(qa_r[1]); a2 = EW'(qa_r[2]); a3 = EW'(qa_r[3]);
    b0 = EW'(qb_r[0]); b1 = EW'(qb_r[1]); b2 = EW'(qb_r[2]); b3 = EW'(qb_r[3]);
    case (ph_r)
      3'd0: begin opx = a0 + a3; opy = b0 + b3; end
      3'd1: begin opx = a2 + a3; opy = b0;      end
      3'd2: begin opx = a0;      opy = b1 - b3; end
      3'd3: begin opx = a3;      opy = b2 - b0; end
      3'd4: begin opx = a0 + a1; opy = b3;      end
      3'd5: begin opx = a2 - a0; opy = b0 + b1; end
      3'd6: begin opx = a1 - a3; opy = b2 + b3; end
      default: begin opx = '0; opy = '0; end
    endcase
  end

  logic signed [OW-1:0] m_r [7];
  logic signed [OW-1:0] c_mem [CDEPTH];
  logic signed [2*EW-1:0] prod;
  assign prod = opx * opy;

  logic mac_en, clr_m, comb_en;
  logic [CW-1:0]        c_row, c_col;
  logic signed [OW-1:0] c_wd;

  always_ff @(posedge clk) begin
    if (clr_m) begin
      for (int k = 0; k < 7; k++) m_r[k] <= '0;
    end else if (mac_en) begin
      m_r[ph_r] <= m_r[ph_r] + OW'(prod);
    end
  end

  // combine: one quadrant block per cycle, block index in ph_r
  always_comb begin
    c_row = CW'(p_r) + (ph_r[1] ? CW'(h_use) : CW'(0));
    c_col = CW'(q_r) + (ph_r[0] ? CW'(h_use) : CW'(0));
    case (ph_r[1:0])
      2'd0: c_wd = m_r[0] + m_r[3] - m_r[4] + m_r[6];
      2'd1: c_wd = m_r[2] + m_r[4];
      2'd2: c_wd = m_r[1] + m_r[3];
      default: c_wd = m_r[0] - m_r[1] + m_r[2] + m_r[5];
    endcase
  end

  always_ff @(posedge clk) begin
    if (comb_en) c_mem[{c_row, c_col}] <= c_wd;
  end

  // output stage
  logic                 ov_r, ov_nxt;
  logic [2:0]           orow_r, ocol_r;
  logic                 olast_r;
  logic signed [OW-1:0] oc_r;
  logic                 out_en, olast;
  assign olast = (32'(oi_r) == 32'(n_use) - 1) && (32'(oj_r) == 32'(n_use) - 1);
  always_ff @(posedge clk) begin
    if (out_en) begin
      oc_r    <= c_mem[{oi_r, oj_r}];
      orow_r  <= 3'(oi_r);
      ocol_r  <= 3'(oj_r);
      olast_r <= olast;
    end
  end
  assign out_valid   = ov_r;
  assign out_c_value = oc_r;
  assign out_row     = orow_r;
  assign out_col     = ocol_r;
  assign out_last    = olast_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; p_nxt = p_r; q_nxt = q_r; r_nxt = r_r; ph_nxt = ph_r;
    oi_nxt = oi_r; oj_nxt = oj_r;
    mac_en = 1'b0; clr_m = 1'b0; comb_en = 1'b0; out_en = 1'b0; ov_nxt = 1'b0;
    case (state_r)
      smm_pkg::ST_LOAD: begin
        if (accept) begin
          if (wr_idx + 1'b1 >= total) begin
            cnt_nxt = '0;
            state_nxt = smm_pkg::ST_RD;
            p_nxt = '0; q_nxt = '0; r_nxt = '0; ph_nxt = '0;
            clr_m = 1'b1;
          end else begin
            cnt_nxt = wr_idx + 1'b1;
          end
        end
      end
      smm_pkg::ST_RD: begin
        // four reads, then the last one lands through the read registers into the quadrant registers
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd5) begin
          ph_nxt = '0;
          state_nxt = smm_pkg::ST_MAC;
        end
      end
      smm_pkg::ST_MAC: begin
        mac_en = 1'b1;
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd6) begin
          ph_nxt = '0;
          if (r_r == h_use - 1'b1) begin
            r_nxt = '0;
            state_nxt = smm_pkg::ST_COMB;
          end else begin
            r_nxt = r_r + 1'b1;
            state_nxt = smm_pkg::ST_RD;
          end
        end
      end
      smm_pkg::ST_COMB: begin
        comb_en = 1'b1;
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd3) begin
          ph_nxt = '0;
          clr_m = 1'b1;
          state_nxt = smm_pkg::ST_RD;
          if (q_r == h_use - 1'b1) begin
            q_nxt = '0;
            if (p_r == h_use - 1'b1) begin
              p_nxt = '0;
              oi_nxt = '0; oj_nxt = '0;
              state_nxt = smm_pkg::ST_OUT;
            end else begin
              p_nxt = p_r + 1'b1;
            end
          end else begin
            q_nxt = q_r + 1'b1;
          end
        end
      end
      smm_pkg::ST_OUT: begin
        out_en = 1'b1;
        ov_nxt = 1'b1;
        if (32'(oj_r) == 32'(n_use) - 1) begin
          oj_nxt = '0;
          oi_nxt = oi_r + 1'b1;
        end else begin
          oj_nxt = oj_r + 1'b1;
        end
        if (olast) state_nxt = smm_pkg::ST_LOAD;
      end
      default: state_nxt = smm_pkg::ST_LOAD;
    endcase
    if (wr_en) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= smm_pkg::ST_LOAD;
      cnt_r      <= '0;
      size_r     <= 4'(MAX_ORDER);
      ov_r       <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      ov_r       <= ov_nxt;
      rd_valid_r <= (state_r == smm_pkg::ST_RD) && (ph_r < 3'd4);
      if (wr_en) size_r <= pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt; q_r <= q_nxt; r_r <= r_nxt; ph_r <= ph_nxt;
    oi_r <= oi_nxt; oj_r <= oj_nxt;
    rd_k_r <= ph_r[1:0];
  end

  // checks
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_busy || out_last)
    else $error("result while idle");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !in_busy)
    else $error("not idle after last result");
  a_no_out_compute: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smm_pkg::ST_MAC) |-> !out_valid)
    else $error("result during compute");

endmodule
